>>> rtl/pi4_dqpsk_multitone_modulator_core_macros.svh
// Assertion helpers shared by the modulator RTL.
// Every check runs on aclk and is disabled while aresetn is low.
`ifndef PI4_DQPSK_MULTITONE_MODULATOR_CORE_MACROS_SVH
`define PI4_DQPSK_MULTITONE_MODULATOR_CORE_MACROS_SVH

// Same-cycle implication
`define P4DQMM_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication
`define P4DQMM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/p4dqmm_pkg.sv
package p4dqmm_pkg;

    // Default build settings
    localparam int NUM_TONES_DEF          = 15;
    localparam int CARRIER_PHASE_BITS_DEF = 32;
    localparam int COS_ADDR_BITS_DEF      = 10;
    localparam int MAX_TONES              = 15;

    // Field and register widths
    localparam int FRAME_BITS_W = 30;
    localparam int SAMPLE_W     = 20;
    localparam int INDEX_W      = 16;
    localparam int AMP_W        = 16;
    localparam int PPH_W        = 24;
    localparam int OFFL_W       = 64;
    localparam int OFFH_W       = 56;
    localparam int OFFSETS_W    = OFFL_W + OFFH_W;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int FREQ_W       = 12;
    localparam int COS_MAG_W    = 16;
    localparam int COS_W        = COS_MAG_W + 1;
    localparam int SUM_W        = 20;
    localparam int SYM_W        = 3;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 40;
    localparam int IN_TUSER_W   = 2;

    // Register reset values
    localparam logic [AMP_W-1:0] AMP_RESET = 16'd16515;
    localparam logic [PPH_W-1:0] PPH_RESET = 24'd536871;

    // Cosine generation constants
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [COS_MAG_W-1:0] Q15_ONE = 16'd32768;

    // Tone frequencies in hertz, tone 1 first
    localparam logic [FREQ_W-1:0] TONE_FREQ [MAX_TONES] = '{
        12'd935,  12'd1045, 12'd1155, 12'd1265, 12'd1375, 12'd1485, 12'd1595, 12'd1705,
        12'd1815, 12'd1925, 12'd2035, 12'd2145, 12'd2255, 12'd2365, 12'd2915
    };

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AMPLITUDE     = 3'd0,
        REG_PHASE_PER_HZ  = 3'd1,
        REG_OFFSETS_LOW   = 3'd2,
        REG_OFFSETS_HIGH  = 3'd3
    } cfg_reg_t;

    // One configuration write
    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // Load enables for the back end of the pipeline
    typedef struct packed {
        logic lane_ld;
        logic part_ld;
        logic total_ld;
        logic out_ld;
    } comb_en_t;

    // Gray-mapped differential step, units of pi/4
    function automatic logic [SYM_W-1:0] dibit_step(input logic [1:0] d);
        logic [SYM_W-1:0] st;
        case (d)
            2'd0:    st = 3'd3;
            2'd1:    st = 3'd1;
            2'd2:    st = 3'd5;
            default: st = 3'd7;
        endcase
        return st;
    endfunction

    // Q30 product, wrapping at 64 bits
    function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b;
        return p >> 30;
    endfunction

    // Round Q30 half up to Q15, clamp to [0, 1.0]
    function automatic logic [COS_MAG_W-1:0] q30_to_q15(input longint v);
        longint r;
        if (v < 0) begin
            return '0;
        end
        r = (v + 64'sd16384) >>> 15;
        if (r > 64'sd32768) begin
            r = 64'sd32768;
        end
        return COS_MAG_W'(r);
    endfunction

    // Table entry for one first-quadrant step: sine in the upper half, cosine below
    function automatic logic [2*COS_MAG_W-1:0] cos_sin_entry(input int unsigned r,
                                                             input int unsigned frac_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        longint      acc_c;
        longint      acc_s;
        x  = (64'(r) * HALF_PI_Q30) >> frac_bits;
        x2 = mul_q30(x, x);
        // cosine series
        t = Q30_ONE;
        acc_c = longint'(t);
        t = mul_q30(t, x2) / 2;   acc_c = acc_c - longint'(t);
        t = mul_q30(t, x2) / 12;  acc_c = acc_c + longint'(t);
        t = mul_q30(t, x2) / 30;  acc_c = acc_c - longint'(t);
        t = mul_q30(t, x2) / 56;  acc_c = acc_c + longint'(t);
        t = mul_q30(t, x2) / 90;  acc_c = acc_c - longint'(t);
        t = mul_q30(t, x2) / 132; acc_c = acc_c + longint'(t);
        // sine series
        t = x;
        acc_s = longint'(t);
        t = mul_q30(t, x2) / 6;   acc_s = acc_s - longint'(t);
        t = mul_q30(t, x2) / 20;  acc_s = acc_s + longint'(t);
        t = mul_q30(t, x2) / 42;  acc_s = acc_s - longint'(t);
        t = mul_q30(t, x2) / 72;  acc_s = acc_s + longint'(t);
        t = mul_q30(t, x2) / 110; acc_s = acc_s - longint'(t);
        t = mul_q30(t, x2) / 156; acc_s = acc_s + longint'(t);
        return {q30_to_q15(acc_s), q30_to_q15(acc_c)};
    endfunction

endpackage

>>> rtl/p4dqmm_phase.sv
module p4dqmm_phase #(
    parameter int NUM_TONES          = p4dqmm_pkg::NUM_TONES_DEF,
    parameter int CARRIER_PHASE_BITS = p4dqmm_pkg::CARRIER_PHASE_BITS_DEF,
    parameter int COS_ADDR_BITS      = p4dqmm_pkg::COS_ADDR_BITS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  p4dqmm_pkg::cfg_wr_t                        cfg,
    input  logic                                       accept,
    input  logic                                       ld,
    input  logic                                       start_message,
    input  logic                                       start_frame,
    input  logic [p4dqmm_pkg::FRAME_BITS_W-1:0]        frame_bits,
    output logic [NUM_TONES-1:0][COS_ADDR_BITS-1:0]    addr,
    output logic [p4dqmm_pkg::INDEX_W-1:0]             sample_index
);
    import p4dqmm_pkg::*;

    localparam int CPB      = CARRIER_PHASE_BITS;
    localparam int STEP_LSB = 32 - CPB;
    localparam int PROD_W   = FREQ_W + PPH_W;

    logic pph_wr;
    logic offl_wr;
    logic offh_wr;

    logic [OFFSETS_W-1:0] offsets_reg;
    logic [INDEX_W-1:0]   counter_reg;
    logic [INDEX_W-1:0]   counter_next;
    logic [INDEX_W-1:0]   index_base;
    logic [INDEX_W-1:0]   index_reg;

    // Decode configuration writes
    always_comb begin
        pph_wr  = 1'b0;
        offl_wr = 1'b0;
        offh_wr = 1'b0;
        if (cfg.en) begin
            unique case (cfg.index)
                REG_PHASE_PER_HZ: pph_wr  = 1'b1;
                REG_OFFSETS_LOW:  offl_wr = 1'b1;
                REG_OFFSETS_HIGH: offh_wr = 1'b1;
                default: ;
            endcase
        end
    end

    // Hold the tone start phases
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offsets_reg <= '0;
        end else begin
            if (offl_wr) begin
                offsets_reg[OFFL_W-1:0] <= cfg.data[OFFL_W-1:0];
            end
            if (offh_wr) begin
                offsets_reg[OFFSETS_W-1:OFFL_W] <= cfg.data[OFFH_W-1:0];
            end
        end
    end

    // Per-tone lanes: symbol phase, carrier phase, table address
    for (genvar k = 0; k < NUM_TONES; k++) begin : g_tone
        localparam logic [PROD_W-1:0] RST_PROD = PROD_W'(TONE_FREQ[k]) * PROD_W'(PPH_RESET);

        logic [PROD_W-1:0] step_prod;
        logic [CPB-1:0]    step_reg;
        logic [SYM_W-1:0]  sym_reg;
        logic [SYM_W-1:0]  sym_base;
        logic [SYM_W-1:0]  sym_next;
        logic [CPB-1:0]    carr_reg;
        logic [CPB-1:0]    carr_base;
        logic [CPB-1:0]    carr_next;
        logic [CPB-1:0]    phase;
        logic [COS_ADDR_BITS-1:0] addr_reg;
        logic [1:0]        dibit;

        // Carrier step is frequency times phase per hertz, set on the write
        assign step_prod = PROD_W'(TONE_FREQ[k]) * PROD_W'(cfg.data[PPH_W-1:0]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                step_reg <= RST_PROD[STEP_LSB +: CPB];
            end else if (pph_wr) begin
                step_reg <= step_prod[STEP_LSB +: CPB];
            end
        end

        // Apply message restart, then the frame dibit
        assign dibit     = {frame_bits[2*k], frame_bits[2*k+1]};
        assign sym_base  = start_message ? '0 : sym_reg;
        assign sym_next  = start_frame ? sym_base + dibit_step(dibit) : sym_base;

        // Reload the carrier on frame start, then advance for the next tick
        assign carr_base = start_frame ? {offsets_reg[8*k +: 8], {(CPB-8){1'b0}}} : carr_reg;
        assign carr_next = carr_base + step_reg;
        assign phase     = carr_base + {sym_next, {(CPB-SYM_W){1'b0}}};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sym_reg  <= '0;
                carr_reg <= '0;
            end else if (accept) begin
                sym_reg  <= sym_next;
                carr_reg <= carr_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (ld) begin
                addr_reg <= phase[CPB-1 -: COS_ADDR_BITS];
            end
        end

        assign addr[k] = addr_reg;
    end

    // Sample counter: restart on frame start, saturate at full scale
    assign index_base   = start_frame ? '0 : counter_reg;
    assign counter_next = (&index_base) ? index_base : index_base + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
        end else if (accept) begin
            counter_reg <= counter_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            index_reg <= index_base;
        end
    end

    assign sample_index = index_reg;

endmodule

>>> rtl/p4dqmm_cos_lane.sv
module p4dqmm_cos_lane #(
    parameter int COS_ADDR_BITS = p4dqmm_pkg::COS_ADDR_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   ld,
    input  logic [COS_ADDR_BITS-1:0]               addr,
    output logic signed [p4dqmm_pkg::COS_W-1:0]    cos_val
);
    import p4dqmm_pkg::*;

    localparam int FRAC_BITS = COS_ADDR_BITS - 2;
    localparam int QDEPTH    = 1 << FRAC_BITS;

    logic [2*COS_MAG_W-1:0]  rom [QDEPTH];
    logic [1:0]              quad;
    logic [FRAC_BITS-1:0]    frac;
    logic [2*COS_MAG_W-1:0]  entry;
    logic [COS_MAG_W-1:0]    c_mag;
    logic [COS_MAG_W-1:0]    s_mag;
    logic signed [COS_W-1:0] val;
    logic signed [COS_W-1:0] cos_reg;

    // First-quadrant sine and cosine table, fixed at elaboration
    for (genvar i = 0; i < QDEPTH; i++) begin : g_rom
        assign rom[i] = cos_sin_entry(i, FRAC_BITS);
    end

    assign quad  = addr[COS_ADDR_BITS-1 -: 2];
    assign frac  = addr[FRAC_BITS-1:0];
    assign entry = rom[frac];
    assign c_mag = entry[COS_MAG_W-1:0];
    assign s_mag = entry[2*COS_MAG_W-1:COS_MAG_W];

    // Fold the quadrant back onto the table
    always_comb begin
        case (quad)
            2'd0:    val =  $signed({1'b0, c_mag});
            2'd1:    val = -$signed({1'b0, s_mag});
            2'd2:    val = -$signed({1'b0, c_mag});
            default: val =  $signed({1'b0, s_mag});
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            cos_reg <= val;
        end
    end

    assign cos_val = cos_reg;

endmodule

>>> rtl/p4dqmm_combine.sv
module p4dqmm_combine #(
    parameter int NUM_TONES = p4dqmm_pkg::NUM_TONES_DEF
) (
    input  logic                                              aclk,
    input  p4dqmm_pkg::comb_en_t                              en,
    input  logic signed [NUM_TONES-1:0][p4dqmm_pkg::COS_W-1:0] cos_val,
    input  logic [p4dqmm_pkg::INDEX_W-1:0]                    index_in,
    input  logic [p4dqmm_pkg::AMP_W-1:0]                      amplitude,
    output logic signed [p4dqmm_pkg::SAMPLE_W-1:0]            sample,
    output logic [p4dqmm_pkg::INDEX_W-1:0]                    sample_index
);
    import p4dqmm_pkg::*;

    localparam int GROUP      = 4;
    localparam int NUM_GROUPS = (NUM_TONES + GROUP - 1) / GROUP;
    localparam int PROD_W     = SUM_W + AMP_W + 1;
    localparam int SCALED_W   = PROD_W - 16;
    localparam logic signed [SCALED_W-1:0] SAT_MAX = SCALED_W'((1 << (SAMPLE_W-1)) - 1);
    localparam logic signed [SCALED_W-1:0] SAT_MIN = -SCALED_W'(1 << (SAMPLE_W-1));

    logic signed [NUM_GROUPS-1:0][SUM_W-1:0] part_reg;
    logic signed [SUM_W-1:0]    total;
    logic signed [SUM_W-1:0]    total_reg;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [SAMPLE_W-1:0] sat;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [INDEX_W-1:0]         idx2_reg;
    logic [INDEX_W-1:0]         idx3_reg;
    logic [INDEX_W-1:0]         idx4_reg;
    logic [INDEX_W-1:0]         idx_out_reg;

    // First tree level: groups of four tones
    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_part
        logic signed [SUM_W-1:0] part;
        always_comb begin
            part = '0;
            for (int j = 0; j < GROUP; j++) begin
                if (g * GROUP + j < NUM_TONES) begin
                    part = part + SUM_W'($signed(cos_val[g * GROUP + j]));
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en.part_ld) begin
                part_reg[g] <= part;
            end
        end
    end

    // Second tree level: total over the groups
    always_comb begin
        total = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            total = total + part_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.total_ld) begin
            total_reg <= total;
        end
    end

    // Scale by amplitude, round half up, saturate
    assign prod   = PROD_W'(total_reg) * $signed({1'b0, amplitude}) + PROD_W'(32768);
    assign scaled = SCALED_W'(prod >>> 16);
    always_comb begin
        if (scaled > SAT_MAX) begin
            sat = SAT_MAX[SAMPLE_W-1:0];
        end else if (scaled < SAT_MIN) begin
            sat = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            sat = scaled[SAMPLE_W-1:0];
        end
    end

    // Carry the sample index alongside the data
    always_ff @(posedge aclk) begin
        if (en.lane_ld) begin
            idx2_reg <= index_in;
        end
        if (en.part_ld) begin
            idx3_reg <= idx2_reg;
        end
        if (en.total_ld) begin
            idx4_reg <= idx3_reg;
        end
        if (en.out_ld) begin
            idx_out_reg <= idx4_reg;
            sample_reg  <= sat;
        end
    end

    assign sample       = sample_reg;
    assign sample_index = idx_out_reg;

endmodule

>>> rtl/pi4_dqpsk_multitone_modulator_core.sv
// pi/4 DQPSK multitone modulator, one output sample per accepted tick.
// Five register stages (phase, cosine, two adder tree levels, amplitude scaling) lie between
// the input transfer and m_tvalid, the first loading on the transfer edge.
// Throughput: one item per cycle while m_tready holds; an empty or moving stage takes a new item.
// Reset: synchronous, active low; clears symbol and carrier phases, sample counter and
// pipeline valids, and loads the registers with their default values.
`include "pi4_dqpsk_multitone_modulator_core_macros.svh"

module pi4_dqpsk_multitone_modulator_core #(
    parameter int NUM_TONES           = p4dqmm_pkg::NUM_TONES_DEF,
    parameter int CARRIER_PHASE_BITS  = p4dqmm_pkg::CARRIER_PHASE_BITS_DEF,
    parameter int COS_TABLE_ADDR_BITS = p4dqmm_pkg::COS_ADDR_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [p4dqmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [p4dqmm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [p4dqmm_pkg::IN_TDATA_W-1:0]     s_tdata,   // [29:0] frame_bits
    input  logic [p4dqmm_pkg::IN_TUSER_W-1:0]     s_tuser,   // [0] start_message, [1] start_frame
    // result stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [p4dqmm_pkg::OUT_TDATA_W-1:0]    m_tdata    // [19:0] sample, [35:20] sample_index
);
    import p4dqmm_pkg::*;

    localparam int STAGES = 5;
    localparam int SAMPLE_BOUND = NUM_TONES * 32768;

    cfg_wr_t  cfg;
    comb_en_t comb_en;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] rdy;
    logic              accept;
    logic [AMP_W-1:0]  amplitude_reg;
    logic              last_moves;
    logic              out_in_bound;

    logic [NUM_TONES-1:0][COS_TABLE_ADDR_BITS-1:0] addr;
    logic signed [NUM_TONES-1:0][COS_W-1:0]        cos_val;
    logic [INDEX_W-1:0]                            index1;
    logic signed [SAMPLE_W-1:0]                    sample;
    logic [INDEX_W-1:0]                            sample_index;

    assign cfg = '{en: cfg_wr_en, index: cfg_index, data: cfg_wdata};

    // Amplitude register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amplitude_reg <= AMP_RESET;
        end else if (cfg_wr_en && cfg_index == REG_AMPLITUDE) begin
            amplitude_reg <= cfg_wdata[AMP_W-1:0];
        end
    end

    // A stage may load when it is empty or its content moves on
    always_comb begin
        rdy[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0];
    assign accept   = s_tvalid && rdy[0];

    // Advance the valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (rdy[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign comb_en = '{lane_ld: rdy[1], part_ld: rdy[2], total_ld: rdy[3], out_ld: rdy[4]};

    p4dqmm_phase #(
        .NUM_TONES          (NUM_TONES),
        .CARRIER_PHASE_BITS (CARRIER_PHASE_BITS),
        .COS_ADDR_BITS      (COS_TABLE_ADDR_BITS)
    ) u_phase (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .accept        (accept),
        .ld            (rdy[0]),
        .start_message (s_tuser[0]),
        .start_frame   (s_tuser[1]),
        .frame_bits    (s_tdata[FRAME_BITS_W-1:0]),
        .addr          (addr),
        .sample_index  (index1)
    );

    for (genvar k = 0; k < NUM_TONES; k++) begin : g_lane
        p4dqmm_cos_lane #(
            .COS_ADDR_BITS (COS_TABLE_ADDR_BITS)
        ) u_lane (
            .aclk    (aclk),
            .ld      (rdy[1]),
            .addr    (addr[k]),
            .cos_val (cos_val[k])
        );
    end

    p4dqmm_combine #(
        .NUM_TONES (NUM_TONES)
    ) u_combine (
        .aclk         (aclk),
        .en           (comb_en),
        .cos_val      (cos_val),
        .index_in     (index1),
        .amplitude    (amplitude_reg),
        .sample       (sample),
        .sample_index (sample_index)
    );

    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = {{(OUT_TDATA_W-SAMPLE_W-INDEX_W){1'b0}}, sample_index, sample};

    // Checks on the pipeline control and the output range
    assign last_moves   = valid_reg[STAGES-2] && rdy[STAGES-1];
    assign out_in_bound = (int'(sample) <= SAMPLE_BOUND) && (int'(sample) >= -SAMPLE_BOUND);

    `P4DQMM_ASSERT_NEXT(a_no_drop, last_moves, m_tvalid, "item lost before output")
    `P4DQMM_ASSERT_NOW(a_room_on_accept, accept && valid_reg[0], rdy[1], "no room for transfer")
    `P4DQMM_ASSERT_NOW(a_sample_range, m_tvalid, out_in_bound, "sample beyond tone sum")

endmodule
